// File: src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  // Default sizes of the store.
  localparam int DepthDefault     = 256;
  localparam int DataWidthDefault = 32;

  // Fixed field widths on the streams.
  localparam int OpcodeW = 4;
  localparam int ValueW  = 32;
  localparam int CountW  = 9;
  localparam int StatusW = 2;

  // Stream widths: slave tdata carries value, slave tuser carries opcode.
  localparam int SDataW = 32;
  localparam int SUserW = OpcodeW;
  // Master tdata: read_data, element_count, padded to whole bytes.
  localparam int MDataW = 48;
  // Master tuser: iter_off_end, status.
  localparam int MUserW = 1 + StatusW;

  // Request opcodes.
  localparam logic [OpcodeW-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OpcodeW-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OpcodeW-1:0] OP_POP_FRONT  = 4'd2;
  localparam logic [OpcodeW-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OpcodeW-1:0] OP_READ_FRONT = 4'd4;
  localparam logic [OpcodeW-1:0] OP_READ_BACK  = 4'd5;
  localparam logic [OpcodeW-1:0] OP_ITER_START = 4'd6;
  localparam logic [OpcodeW-1:0] OP_ITER_NEXT  = 4'd7;
  localparam logic [OpcodeW-1:0] OP_ITER_READ  = 4'd8;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd2;
  localparam logic [StatusW-1:0] ST_OFF_END = 2'd3;

  // Everything about a result except the word read from the store.
  typedef struct packed {
    logic               use_mem;
    logic [CountW-1:0]  count;
    logic               off_end;
    logic [StatusW-1:0] status;
  } deq_result_t;

endpackage

// File: src/double_ended_queue_unit.sv
// Bounded double-ended queue of signed words held in a single-port ring memory. Each request
// transaction (opcode on s_axis_tuser, value on s_axis_tdata) pushes or pops at either end, reads
// the front or back, or starts, advances or reads an iterator, and gives exactly one result
// transaction carrying the word read (zero when nothing is read), the element count after the
// request, an iterator-off-end flag and a status (ok, empty, full, iterator off end). A push to a
// full queue is dropped and reported as full. The iterator names a physical slot, so pushes leave
// it on the same element, and popping the element under it moves it off end. One request is
// taken every cycle while the result side keeps up. A result is offered once it reaches the
// output register: the ring memory registers the word read at the accepting edge, while the
// pending stage holds the rest of the result, and the output register takes both once it is
// empty or being drained. A result that waits for the consumer is held in the output register,
// and one further request is taken meanwhile.
// The memory contents are not cleared after reset; no entry is read before it has been written.
`timescale 1ns / 1ps

module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DepthDefault,
  parameter int DATA_WIDTH = deq_pkg::DataWidthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [deq_pkg::SDataW-1:0] s_axis_tdata,   // [31:0] value
  input  logic [deq_pkg::SUserW-1:0] s_axis_tuser,   // [3:0] opcode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [deq_pkg::MDataW-1:0] m_axis_tdata,   // [31:0] read_data, [40:32] element_count
  output logic [deq_pkg::MUserW-1:0] m_axis_tuser    // [0] iter_off_end, [2:1] status
);

  localparam int AW = $clog2(DEPTH);

  // Request side handshake.
  logic accept;

  // Memory port driven by the controller.
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // Result stage that waits for the memory read data.
  deq_pkg::deq_result_t  result;
  deq_pkg::deq_result_t  pend_q;
  logic                  pend_valid_q, pend_valid_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [deq_pkg::ValueW-1:0]    out_data_q;
  logic [deq_pkg::CountW-1:0]    out_count_q;
  logic                          out_off_end_q;
  logic [deq_pkg::StatusW-1:0]   out_status_q;
  logic                          out_free;
  logic                          pend_move;

  // The output register can take a result when it is empty or being drained this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign pend_move     = pend_valid_q && out_free;
  // A new request may enter whenever the pending stage is empty or moves on.
  assign s_axis_tready = !pend_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (s_axis_tuser[deq_pkg::OpcodeW-1:0]),
    .value_i     (s_axis_tdata[deq_pkg::ValueW-1:0]),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .result_o    (result)
  );

  // The memory read data holds until the next read, which happens only when the next
  // request is accepted, and that is only once the pending result has moved on.
  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (accept) begin
      pend_valid_d = 1'b1;
    end else if (pend_move) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= result;
    end
    if (pend_move) begin
      out_data_q    <= pend_q.use_mem ? deq_pkg::ValueW'($signed(mem_rdata)) : '0;
      out_count_q   <= pend_q.count;
      out_off_end_q <= pend_q.off_end;
      out_status_q  <= pend_q.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (deq_pkg::MDataW - deq_pkg::ValueW - deq_pkg::CountW)'(0), out_count_q, out_data_q
  };
  assign m_axis_tuser  = {out_status_q, out_off_end_q};

endmodule

// File: src/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int DEPTH      = deq_pkg::DepthDefault,
  parameter int DATA_WIDTH = deq_pkg::DataWidthDefault,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Single port: one write or one read per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DepthDefault,
  parameter int DATA_WIDTH = deq_pkg::DataWidthDefault,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [deq_pkg::OpcodeW-1:0]   opcode_i,
  input  logic [deq_pkg::ValueW-1:0]    value_i,
  output logic                          mem_we_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_addr_o,
  output logic [DATA_WIDTH-1:0]         mem_wdata_o,
  output deq_pkg::deq_result_t          result_o
);

  localparam int SW = CW + 1;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] iter_q, iter_d;
  logic          iter_valid_q, iter_valid_d;

  logic [AW-1:0] front_nx, front_pv, iter_nx, tail, back;
  logic [SW-1:0] sum_tail, sum_back;
  logic          full, empty;
  logic [deq_pkg::StatusW-1:0] status;
  logic          use_mem;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign front_nx = next_slot(front_q);
  assign front_pv = prev_slot(front_q);
  assign iter_nx  = next_slot(iter_q);

  // Ring positions of the slot after the back and of the back itself.
  assign sum_tail = SW'(front_q) + SW'(count_q);
  assign sum_back = sum_tail - 1'b1;
  assign tail     = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
  assign back     = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);

  assign mem_wdata_o = DATA_WIDTH'($signed(value_i));

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    iter_d       = iter_q;
    iter_valid_d = iter_valid_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_addr_o   = front_q;
    status       = deq_pkg::ST_OK;
    use_mem      = 1'b0;
    if (accept_i) begin
      case (opcode_i)
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status = deq_pkg::ST_FULL;
          end else begin
            front_d    = front_pv;
            count_d    = count_q + 1'b1;
            mem_we_o   = 1'b1;
            mem_addr_o = front_pv;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status = deq_pkg::ST_FULL;
          end else begin
            count_d    = count_q + 1'b1;
            mem_we_o   = 1'b1;
            mem_addr_o = tail;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status = deq_pkg::ST_EMPTY;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = front_q;
            use_mem    = 1'b1;
            front_d    = front_nx;
            count_d    = count_q - 1'b1;
            if (iter_valid_q && iter_q == front_q) begin
              iter_valid_d = 1'b0;
            end
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status = deq_pkg::ST_EMPTY;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = back;
            use_mem    = 1'b1;
            count_d    = count_q - 1'b1;
            if (iter_valid_q && iter_q == back) begin
              iter_valid_d = 1'b0;
            end
          end
        end
        deq_pkg::OP_READ_FRONT, deq_pkg::OP_READ_BACK: begin
          if (empty) begin
            status = deq_pkg::ST_EMPTY;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = (opcode_i == deq_pkg::OP_READ_FRONT) ? front_q : back;
            use_mem    = 1'b1;
          end
        end
        deq_pkg::OP_ITER_START: begin
          if (empty) begin
            iter_valid_d = 1'b0;
            status       = deq_pkg::ST_EMPTY;
          end else begin
            iter_d       = front_q;
            iter_valid_d = 1'b1;
            mem_re_o     = 1'b1;
            mem_addr_o   = front_q;
            use_mem      = 1'b1;
          end
        end
        deq_pkg::OP_ITER_NEXT: begin
          if (!iter_valid_q) begin
            status = deq_pkg::ST_OFF_END;
          end else if (iter_q == back) begin
            iter_valid_d = 1'b0;
            status       = deq_pkg::ST_OFF_END;
          end else begin
            iter_d     = iter_nx;
            mem_re_o   = 1'b1;
            mem_addr_o = iter_nx;
            use_mem    = 1'b1;
          end
        end
        deq_pkg::OP_ITER_READ: begin
          if (!iter_valid_q) begin
            status = deq_pkg::ST_OFF_END;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = iter_q;
            use_mem    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= '0;
      count_q      <= '0;
      iter_q       <= '0;
      iter_valid_q <= 1'b0;
    end else begin
      front_q      <= front_d;
      count_q      <= count_d;
      iter_q       <= iter_d;
      iter_valid_q <= iter_valid_d;
    end
  end

  assign result_o.use_mem = use_mem;
  assign result_o.count   = deq_pkg::CountW'(count_d);
  assign result_o.off_end = !iter_valid_d;
  assign result_o.status  = status;

endmodule

// File: src/deq_chk.sv
`timescale 1ns / 1ps

module deq_chk #(
  parameter int DEPTH = deq_pkg::DepthDefault
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [deq_pkg::MDataW-1:0] m_axis_tdata,
  input logic [deq_pkg::MUserW-1:0] m_axis_tuser
);

  logic [deq_pkg::ValueW-1:0]  rd_data;
  logic [deq_pkg::CountW-1:0]  count;
  logic                        off_end;
  logic [deq_pkg::StatusW-1:0] status;

  assign rd_data = m_axis_tdata[deq_pkg::ValueW-1:0];
  assign count   = m_axis_tdata[deq_pkg::ValueW +: deq_pkg::CountW];
  assign off_end = m_axis_tuser[0];
  assign status  = m_axis_tuser[deq_pkg::MUserW-1:1];

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A dropped push only happens at full capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == deq_pkg::ST_FULL |->
      count == deq_pkg::CountW'(DEPTH) && rd_data == '0)
    else $error("full status with wrong count or data");

  // An empty queue cannot leave the iterator on an element.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == deq_pkg::ST_EMPTY |->
      count == '0 && off_end && rd_data == '0)
    else $error("empty status inconsistent");

  a_off_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == deq_pkg::ST_OFF_END |-> off_end && rd_data == '0)
    else $error("off-end status with iterator on an element");

  // With nothing held, the iterator must be off end.
  a_count_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count == '0 |-> off_end)
    else $error("iterator on an element of an empty queue");

endmodule

bind double_ended_queue_unit deq_chk #(
  .DEPTH (DEPTH)
) u_deq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/double_ended_queue_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the deque unit. Requests go in on the slave stream, and every result
// transaction on the master stream is checked field by field against a mirror of the deque
// kept here. A short table of directed requests comes first. Random episodes follow: filling to
// full, draining to empty, mixed traffic, and iterator walks with pops and pushes interleaved.
module double_ended_queue_unit_test;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 6;
  localparam int SlotCount     = deq_pkg::DepthDefault;
  localparam int IndexW        = $clog2(SlotCount);
  localparam int DirectedRows  = 25;
  localparam int ItemsPerPhase = 330;
  localparam int SettleCycles  = 10;
  localparam int MaxGap        = 20;
  localparam int MaxPrinted    = 30;
  localparam int TimeoutNs     = 3_000_000;

  // Opcodes past the last defined one; the unit must ignore them.
  localparam logic [deq_pkg::OpcodeW-1:0] OP_UNUSED_FIRST = 4'd9;
  localparam logic [deq_pkg::OpcodeW-1:0] OP_UNUSED_LAST  = 4'd15;

  // One expected result transaction.
  typedef struct packed {
    logic [deq_pkg::ValueW-1:0]  data;
    logic [deq_pkg::CountW-1:0]  count;
    logic                        off_end;
    logic [deq_pkg::StatusW-1:0] status;
  } deq_expect_t;

  // A row of the directed table. Where typed is set, want is the result written out by hand and
  // it is expected instead of the mirror's answer; the mirror still tracks the request.
  typedef struct packed {
    logic [deq_pkg::OpcodeW-1:0] op;
    logic [deq_pkg::ValueW-1:0]  value;
    bit                          typed;
    deq_expect_t                 want;
  } directed_row_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [deq_pkg::SDataW-1:0]   s_axis_tdata  = '0;
  logic [deq_pkg::SUserW-1:0]   s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [deq_pkg::MDataW-1:0]   m_axis_tdata;
  logic [deq_pkg::MUserW-1:0]   m_axis_tuser;

  // Mirror of the deque contents and pointers.
  logic [deq_pkg::ValueW-1:0]   slot_mirror [SlotCount];
  logic [IndexW-1:0]            front_slot    = '0;
  logic [IndexW-1:0]            iter_slot     = '0;
  logic [deq_pkg::CountW-1:0]   elements_held = '0;
  logic                         iter_on       = 1'b0;

  deq_expect_t         pending_results [$];

  int                  sender_idle_pct    = 0;
  int                  receiver_idle_pct  = 0;
  bit                  hold_until_drained = 1'b0;
  int                  requests_sent      = 0;
  int                  results_checked    = 0;
  int                  mismatches         = 0;
  int                  full_refusals      = 0;
  int                  empty_hits         = 0;
  int                  off_end_hits       = 0;

  directed_row_t directed_rows [DirectedRows] = '{
    // Everything on an empty deque, with the iterator off end since reset.
    '{deq_pkg::OP_READ_FRONT, 32'h0000_0000, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_EMPTY}},
    '{deq_pkg::OP_POP_BACK, 32'hDEAD_BEEF, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_EMPTY}},
    '{deq_pkg::OP_POP_FRONT, 32'h0000_0000, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_EMPTY}},
    '{deq_pkg::OP_READ_BACK, 32'h0000_0000, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_EMPTY}},
    '{deq_pkg::OP_ITER_START, 32'h0000_0000, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_EMPTY}},
    '{deq_pkg::OP_ITER_NEXT, 32'h0000_0000, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_OFF_END}},
    '{deq_pkg::OP_ITER_READ, 32'h0000_0000, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_OFF_END}},
    '{OP_UNUSED_LAST, 32'hFFFF_FFFF, 1'b1, '{32'h0, 9'd0, 1'b1, deq_pkg::ST_OK}},
    // Extreme words at both ends; the push to the front wraps below slot zero.
    '{deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b1, '{32'h0, 9'd1, 1'b1, deq_pkg::ST_OK}},
    '{deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0, 9'd2, 1'b1, deq_pkg::ST_OK}},
    '{deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b1, '{32'h0, 9'd3, 1'b1, deq_pkg::ST_OK}},
    '{deq_pkg::OP_READ_FRONT, 32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd3, 1'b1, deq_pkg::ST_OK}},
    '{deq_pkg::OP_READ_BACK, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 9'd3, 1'b1, deq_pkg::ST_OK}},
    '{deq_pkg::OP_ITER_START, 32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd3, 1'b0, deq_pkg::ST_OK}},
    '{deq_pkg::OP_ITER_NEXT, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 9'd3, 1'b0, deq_pkg::ST_OK}},
    '{deq_pkg::OP_ITER_READ, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 9'd3, 1'b0, deq_pkg::ST_OK}},
    // Pop at the back while the iterator sits elsewhere, then advance past the back.
    '{deq_pkg::OP_POP_BACK, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 9'd2, 1'b0, deq_pkg::ST_OK}},
    '{deq_pkg::OP_ITER_NEXT, 32'h0000_0000, 1'b1, '{32'h0, 9'd2, 1'b1, deq_pkg::ST_OFF_END}},
    '{deq_pkg::OP_ITER_START, 32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd2, 1'b0, deq_pkg::ST_OK}},
    '{deq_pkg::OP_PUSH_BACK, 32'h0000_0001, 1'b0, '0},
    // Popping the element under the iterator sends it off end.
    '{deq_pkg::OP_POP_FRONT, 32'h0000_0000, 1'b1, '{32'h8000_0000, 9'd2, 1'b1, deq_pkg::ST_OK}},
    '{OP_UNUSED_FIRST, 32'h1234_5678, 1'b0, '0},
    '{deq_pkg::OP_ITER_START, 32'h0000_0000, 1'b0, '0},
    '{deq_pkg::OP_POP_BACK, 32'h0000_0000, 1'b0, '0},
    // Popping the only element, which is also under the iterator, leaves a clean empty deque.
    '{deq_pkg::OP_POP_BACK, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 9'd0, 1'b1, deq_pkg::ST_OK}}
  };

  double_ended_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [31:0] value
    .s_axis_tuser  (s_axis_tuser),    // [3:0] opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [31:0] read_data, [40:32] element_count
    .m_axis_tuser  (m_axis_tuser)     // [0] iter_off_end, [2:1] status
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Applies one request to the mirror and returns the result transaction it should give.
  function automatic deq_expect_t apply_request(input logic [deq_pkg::OpcodeW-1:0] op,
                                                input logic [deq_pkg::ValueW-1:0] val);
    deq_expect_t       res;
    logic [IndexW-1:0] back;
    logic [IndexW-1:0] s;
    res  = '0;
    back = front_slot + elements_held[IndexW-1:0] - 1'b1;
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (elements_held == SlotCount) begin
          res.status = deq_pkg::ST_FULL;
          full_refusals++;
        end else if (op == deq_pkg::OP_PUSH_FRONT) begin
          front_slot = front_slot - 1'b1;
          slot_mirror[front_slot] = val;
          elements_held = elements_held + 1'b1;
        end else begin
          s = front_slot + elements_held[IndexW-1:0];
          slot_mirror[s] = val;
          elements_held = elements_held + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (elements_held == 0) begin
          res.status = deq_pkg::ST_EMPTY;
          empty_hits++;
        end else begin
          s = (op == deq_pkg::OP_POP_FRONT) ? front_slot : back;
          res.data = slot_mirror[s];
          if (iter_on && iter_slot == s) iter_on = 1'b0;
          if (op == deq_pkg::OP_POP_FRONT) front_slot = s + 1'b1;
          elements_held = elements_held - 1'b1;
        end
      end
      deq_pkg::OP_READ_FRONT, deq_pkg::OP_READ_BACK: begin
        if (elements_held == 0) begin
          res.status = deq_pkg::ST_EMPTY;
          empty_hits++;
        end else begin
          res.data = slot_mirror[(op == deq_pkg::OP_READ_FRONT) ? front_slot : back];
        end
      end
      deq_pkg::OP_ITER_START: begin
        if (elements_held == 0) begin
          iter_on = 1'b0;
          res.status = deq_pkg::ST_EMPTY;
          empty_hits++;
        end else begin
          iter_slot = front_slot;
          iter_on = 1'b1;
          res.data = slot_mirror[iter_slot];
        end
      end
      deq_pkg::OP_ITER_NEXT: begin
        if (!iter_on) begin
          res.status = deq_pkg::ST_OFF_END;
        end else if (iter_slot == back) begin
          // Stepping past the back element leaves the iterator off end.
          iter_on = 1'b0;
          res.status = deq_pkg::ST_OFF_END;
        end else begin
          iter_slot = iter_slot + 1'b1;
          res.data = slot_mirror[iter_slot];
        end
      end
      deq_pkg::OP_ITER_READ: begin
        if (!iter_on) res.status = deq_pkg::ST_OFF_END;
        else res.data = slot_mirror[iter_slot];
      end
      default: begin
      end
    endcase
    if (res.status == deq_pkg::ST_OFF_END) off_end_hits++;
    res.count   = elements_held;
    res.off_end = !iter_on;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [deq_pkg::ValueW-1:0] got,
                                 input logic [deq_pkg::ValueW-1:0] want);
    if (mismatches < MaxPrinted)
      $display("%0t ns: %s differs: got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  // Sends one request transaction, idling beforehand as the current phase asks, and records
  // the result it should give once the unit has accepted it.
  task automatic send_request(input logic [deq_pkg::OpcodeW-1:0] op,
                              input logic [deq_pkg::ValueW-1:0] val,
                              input bit typed, input deq_expect_t typed_res);
    int          gap;
    deq_expect_t res;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0 || (hold_until_drained && pending_results.size() != 0)) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (hold_until_drained && pending_results.size() != 0) @(posedge clk_i);
    end
    hold_until_drained = 1'b0;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = apply_request(op, val);
    pending_results.push_back(typed ? typed_res : res);
    if (op <= deq_pkg::OP_ITER_READ) requests_sent++;
  endtask

  // Mostly random words, with the extremes turning up often.
  function automatic logic [deq_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [deq_pkg::OpcodeW-1:0] any_op();
    return deq_pkg::OpcodeW'($urandom_range(deq_pkg::OP_ITER_READ));
  endfunction

  // Sends the given operation with a random word, now and then preceded by an ignored opcode
  // and now and then after letting every outstanding result come back first.
  task automatic send_op(input logic [deq_pkg::OpcodeW-1:0] op);
    if ($urandom_range(99) < 3)
      send_request(deq_pkg::OpcodeW'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                   pick_value(), 1'b0, '0);
    if ($urandom_range(199) == 0) hold_until_drained = 1'b1;
    send_request(op, pick_value(), 1'b0, '0);
  endtask

  // Pushes at random ends until the deque is full, then a few refused pushes beyond that.
  task automatic fill_episode();
    int extra;
    extra = $urandom_range(3, 1);
    while (extra > 0) begin
      if ($urandom_range(99) < 12) begin
        send_op(any_op());
      end else begin
        if (elements_held == SlotCount) extra--;
        send_op($urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT);
      end
    end
  endtask

  // Pops at random ends until the deque is empty, then a few pops on the empty deque.
  task automatic drain_episode();
    int extra;
    extra = $urandom_range(3, 1);
    while (extra > 0) begin
      if ($urandom_range(99) < 12) begin
        send_op(any_op());
      end else begin
        if (elements_held == 0) extra--;
        send_op($urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT);
      end
    end
  endtask

  task automatic mixed_episode();
    repeat ($urandom_range(40, 10)) send_op(any_op());
  endtask

  // Starts the iterator and walks it towards the back while the ends are pushed and popped,
  // so that it is popped from under or runs off the back.
  task automatic iterator_walk();
    int steps;
    int pick;
    if (elements_held == 0) repeat ($urandom_range(8, 3)) send_op(deq_pkg::OP_PUSH_BACK);
    send_op(deq_pkg::OP_ITER_START);
    steps = 0;
    while (iter_on && steps < 60) begin
      pick = $urandom_range(99);
      if (pick < 60) send_op(deq_pkg::OP_ITER_NEXT);
      else if (pick < 75) send_op(deq_pkg::OP_ITER_READ);
      else if (pick < 83) send_op(deq_pkg::OP_POP_FRONT);
      else if (pick < 91) send_op(deq_pkg::OP_POP_BACK);
      else send_op(pick[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK);
      steps++;
    end
    send_op(deq_pkg::OP_ITER_READ);
    send_op(deq_pkg::OP_ITER_NEXT);
  endtask

  // The receiver stalls at random while its idle share is above zero.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Every result transaction is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    deq_expect_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", m_axis_tdata[deq_pkg::ValueW-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[deq_pkg::ValueW-1:0] !== want.data)
          report_mismatch("read_data", m_axis_tdata[deq_pkg::ValueW-1:0], want.data);
        if (m_axis_tdata[deq_pkg::ValueW +: deq_pkg::CountW] !== want.count)
          report_mismatch("element_count", m_axis_tdata[deq_pkg::ValueW +: deq_pkg::CountW],
                          want.count);
        if (m_axis_tuser[0] !== want.off_end)
          report_mismatch("iter_off_end", m_axis_tuser[0], want.off_end);
        if (m_axis_tuser[deq_pkg::StatusW:1] !== want.status)
          report_mismatch("status", m_axis_tuser[deq_pkg::StatusW:1], want.status);
        results_checked++;
      end
    end
  end

  initial begin
    int episode;
    episode = 0;
    // The first phase stalls mostly on the result side, the second mostly on the request side,
    // and the third runs at full rate in both directions.
    sender_idle_pct   = 30;
    receiver_idle_pct = 84;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct    = (phase == 0) ? 30 : (phase == 1) ? 84 : 0;
      receiver_idle_pct  = (phase == 0) ? 84 : (phase == 1) ? 30 : 0;
      hold_until_drained = 1'b1;
      while (requests_sent < DirectedRows + (phase + 1) * ItemsPerPhase) begin
        case (episode % 5)
          0: fill_episode();
          3: drain_episode();
          default: begin
            if ($urandom_range(1)) mixed_episode();
            else iterator_walk();
          end
        endcase
        episode++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d requests in %0d episodes: %0d pushes refused as full,",
             requests_sent, episode, full_refusals);
    $display("%0d on an empty deque, %0d with the iterator off end; %0d results checked.",
             empty_hits, off_end_hits, results_checked);
    if (mismatches == 0) begin
      $display("double_ended_queue_unit: match");
    end else begin
      $display("double_ended_queue_unit: mismatch");
    end
    $finish;
  end

  // Guards against a stalled handshake.
  initial begin
    #TimeoutNs;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("double_ended_queue_unit: mismatch");
    $finish;
  end

endmodule

// File: files.f
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/double_ended_queue_unit.sv
src/deq_chk.sv
tb/double_ended_queue_unit_test.sv
